// ===== hw/rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants of the sorted priority queue: field widths,
// status and mode codes, sequencer states and the result bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // field widths fixed by the interface
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int STAT_W = 2;
  localparam int OCC_W  = 5;

  // default store depth and capacity after reset
  localparam int DEPTH_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // item modes
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_RM_HEAD,
    S_RM_SHIFT,
    S_DONE
  } spq_state_t;

  // one finished result, sequencer to output stage
  typedef struct packed {
    logic [DATA_W-1:0] removed_value;
    status_t           status;
    logic [OCC_W-1:0]  occupancy;
  } spq_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/spq_ram.sv =====
// ----------------------------------------------------------------------------
// spq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/spq_seq.sv =====
// ----------------------------------------------------------------------------
// spq_seq
// Sequencer of the queue: walks the sorted store one entry per cycle through
// a single signed compare, shifting entries down on insert and up on remove.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_seq
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // item side
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_mode,
  input  wire logic [DATA_W-1:0]        in_value,
  input  wire logic [CAP_W-1:0]         capacity,
  // result side
  input  wire logic                     out_free,
  output logic                          res_valid,
  output spq_res_t                      res,
  // store port
  output logic                          ram_we,
  output logic      [$clog2(DEPTH)-1:0] ram_waddr,
  output logic      [DATA_W-1:0]        ram_wdata,
  output logic      [$clog2(DEPTH)-1:0] ram_raddr,
  input  wire logic [DATA_W-1:0]        ram_rdata
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  spq_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]     idx_r, idx_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [DATA_W-1:0] removed_r, removed_nxt;
  status_t           status_r, status_nxt;

  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  cap_ext;
  logic [CNT_W-1:0]  idx_ext;
  logic              full;
  logic              le_hit;
  logic              more_shift;

  // full when count reaches capacity or the store depth
  assign cnt_ext = CMP_W'(cnt_r);
  assign cap_ext = CMP_W'(capacity);
  assign full    = (cnt_ext >= cap_ext) || (cnt_r == CNT_W'(DEPTH));

  // shared signed compare: stored entry not above the new value
  assign le_hit = $signed(ram_rdata) <= $signed(val_r);

  // remove walk still has entries behind the current one
  assign idx_ext    = CNT_W'(idx_r);
  assign more_shift = (idx_ext + CNT_W'(1)) < cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_mode == MODE_INSERT) begin
            if (full) begin
              state_nxt = S_DONE;
            end else if (cnt_r == '0) begin
              state_nxt = S_INS_PUT;
            end else begin
              state_nxt = S_INS_CMP;
            end
          end else begin
            if (cnt_r == '0) begin
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_RM_HEAD;
            end
          end
        end
      end
      S_INS_CMP: begin
        if (!(le_hit && (idx_r != AW'(1)))) begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        state_nxt = S_DONE;
      end
      S_RM_HEAD: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RM_SHIFT;
        end
      end
      S_RM_SHIFT: begin
        if (!more_shift) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // datapath and store control
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = idx_r;
    ram_wdata   = val_r;
    ram_raddr   = '0;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    val_nxt     = val_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt     = in_value;
          removed_nxt = '0;
          status_nxt  = ST_OK;
          if (in_mode == MODE_INSERT) begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              // start at the tail, read the last entry
              idx_nxt   = cnt_r[AW-1:0];
              ram_raddr = cnt_r[AW-1:0] - AW'(1);
            end
          end else begin
            if (cnt_r == '0) begin
              status_nxt = ST_EMPTY;
            end
          end
        end
      end
      S_INS_CMP: begin
        // move a smaller or equal entry one slot back
        if (le_hit) begin
          ram_we    = 1'b1;
          ram_waddr = idx_r;
          ram_wdata = ram_rdata;
          idx_nxt   = idx_r - AW'(1);
          ram_raddr = idx_r - AW'(2);
        end
      end
      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = val_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
      end
      S_RM_HEAD: begin
        removed_nxt = ram_rdata;
        if (cnt_r == CNT_W'(1)) begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end else begin
          ram_raddr = AW'(1);
          idx_nxt   = AW'(1);
        end
      end
      S_RM_SHIFT: begin
        // move each entry one slot forward
        ram_we    = 1'b1;
        ram_waddr = idx_r - AW'(1);
        ram_wdata = ram_rdata;
        if (more_shift) begin
          ram_raddr = idx_r + AW'(1);
          idx_nxt   = idx_r + AW'(1);
        end else begin
          cnt_nxt = cnt_r - CNT_W'(1);
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // handshake and result
  assign in_ready          = (state_r == S_IDLE);
  assign res_valid         = (state_r == S_DONE);
  assign res.removed_value = removed_r;
  assign res.status        = status_r;
  assign res.occupancy     = cnt_ext[OCC_W-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    val_r     <= val_nxt;
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded max-priority queue of signed 32-bit values kept sorted in a RAM.
//
// Usage: an input transfer (in_valid & in_ready) carries in_mode and
// in_value. Insert (mode 0) places the value ahead of all smaller or equal
// entries, so equal values leave last in, first out; it is refused with full
// status once the count reaches cfg capacity (or DEPTH). Remove (mode 1)
// returns the largest entry, or empty status with value 0. Each item gives
// one result transfer (out_valid & out_ready) with status and occupancy.
// Operation: the sequencer moves one entry per cycle through the single RAM
// read and write port. An insert walks from the tail, shifting smaller or
// equal entries back until its slot is found, then writes the value; a
// remove reads the head and shifts the rest forward; refused items go to the result.
// in_ready returns in the same cycle the result is loaded, so a new item is
// taken only once the previous one is finished. A result waiting on a stalled
// receiver sits in the output register; the sequencer then holds its next
// result until it frees.
// Reset empties the queue and sets capacity to 16; the store is not cleared.
// cfg_wr_en writes capacity at once and is meant for idle periods only.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // configuration
  input  wire logic              cfg_wr_en,
  input  wire logic [CAP_W-1:0]  cfg_wr_data,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_mode,
  input  wire logic [DATA_W-1:0] in_value,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic      [DATA_W-1:0] out_removed_value,
  output logic      [STAT_W-1:0] out_status,
  output logic      [OCC_W-1:0]  out_occupancy
);

  localparam int AW = $clog2(DEPTH);

  logic [CAP_W-1:0]  cap_r;
  logic              out_valid_r;
  spq_res_t          out_res_r;
  logic              out_free;
  logic              res_valid;
  spq_res_t          res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  // capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  // sequencer
  spq_seq #(
    .DEPTH (DEPTH)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_value  (in_value),
    .capacity  (cap_r),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // sorted entry store
  spq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register, free when empty or being drained
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_res_r.removed_value;
  assign out_status        = out_res_r.status;
  assign out_occupancy     = out_res_r.occupancy;

endmodule

`default_nettype wire

// ===== hw/rtl/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks of the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_checker
  import spq_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [DATA_W-1:0] out_removed_value,
  input wire logic [STAT_W-1:0] out_status,
  input wire logic [OCC_W-1:0]  out_occupancy
);

  // reset drops any pending result
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result still valid after reset");

  // a stalled result holds until its transfer
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_removed_value)
      && $stable(out_status) && $stable(out_occupancy))
    else $error("stalled result changed");

  // an empty remove reports an empty queue and a zero value
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |->
      (out_removed_value == '0) && (out_occupancy == '0))
    else $error("empty status with data or entries");

  // a refused insert returns no value
  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_removed_value == '0))
    else $error("full status with a removed value");

endmodule

bind sorted_priority_queue_unit spq_checker u_spq_checker (.*);

`default_nettype wire

// ===== tb/tb_sorted_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_unit
// Self-checking bench for the sorted priority queue. A behavioral copy of the
// queue predicts status, removed value and occupancy for every accepted
// item. Directed cases cover empty removes, value extremes, ties and capacity
// corners. Random burst traffic then runs under several capacities and
// idle/stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sorted_priority_queue_unit
  import spq_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = DEPTH_DEF;

  // dut ports
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]  cfg_wr_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_mode = MODE_INSERT;
  logic [DATA_W-1:0] in_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_removed_value;
  logic [STAT_W-1:0] out_status;
  logic [OCC_W-1:0]  out_occupancy;

  // shadow queue, held in descending order
  logic signed [DATA_W-1:0] shadow_entries[$];
  logic [CAP_W-1:0]         shadow_capacity;
  spq_res_t                 pending_results[$];
  int                       error_count = 0;
  int                       send_idle_pct = 0;
  int                       stall_pct = 0;

  sorted_priority_queue_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_removed_value (out_removed_value),
    .out_status        (out_status),
    .out_occupancy     (out_occupancy)
  );

  // clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // apply one item to the shadow queue and queue up its result
  function automatic void apply_queue_op(input logic mode, input logic [DATA_W-1:0] value);
    spq_res_t res;
    int       limit;
    int       pos;
    res.removed_value = '0;
    res.status = ST_OK;
    limit = (shadow_capacity < QUEUE_DEPTH) ? int'(shadow_capacity) : QUEUE_DEPTH;
    if (mode == MODE_INSERT) begin
      if (shadow_entries.size() >= limit) begin
        res.status = ST_FULL;
      end else begin
        // new value goes ahead of every smaller or equal entry
        pos = 0;
        while (pos < shadow_entries.size() && shadow_entries[pos] > $signed(value))
          pos++;
        shadow_entries.insert(pos, $signed(value));
      end
    end else begin
      if (shadow_entries.size() == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.removed_value = shadow_entries.pop_front();
      end
    end
    res.occupancy = OCC_W'(shadow_entries.size());
    pending_results.push_back(res);
  endfunction

  // one input transfer
  task automatic send_item(input logic mode, input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= mode;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    apply_queue_op(mode, value);
  endtask

  // drop valid and wait until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // capacity write, only with the block idle
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= cap;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shadow_capacity = cap;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0: return DATA_W'($urandom_range(6)) - 32'd3;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    spq_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: removed_value %0d status %0d occupancy %0d",
                 $time, $signed(out_removed_value), out_status, out_occupancy);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_removed_value !== want.removed_value) begin
          $display("%0t removed_value expected %0d actual %0d", $time,
                   $signed(want.removed_value), $signed(out_removed_value));
          error_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t status expected %0d actual %0d", $time, want.status, out_status);
          error_count++;
        end
        if (out_occupancy !== want.occupancy) begin
          $display("%0t occupancy expected %0d actual %0d", $time,
                   want.occupancy, out_occupancy);
          error_count++;
        end
      end
    end
  end

  // removes on an empty queue, value field ignored
  task automatic test_empty_remove();
    send_item(MODE_REMOVE, 32'h0000_0000);
    send_item(MODE_REMOVE, 32'hffff_ffff);
  endtask

  // extremes, ties and ordering
  task automatic test_extremes_and_ties();
    send_item(MODE_INSERT, 32'h7fff_ffff);
    send_item(MODE_INSERT, 32'h8000_0000);
    send_item(MODE_INSERT, 32'h0000_0000);
    send_item(MODE_INSERT, 32'hffff_ffff);
    send_item(MODE_INSERT, 32'd5);
    send_item(MODE_INSERT, 32'd5);
    repeat (7) send_item(MODE_REMOVE, 32'h5555_aaaa);
  endtask

  // capacity lowered below occupancy, then zero capacity
  task automatic test_capacity_corners();
    write_capacity(5'd16);
    send_item(MODE_INSERT, 32'd10);
    send_item(MODE_INSERT, 32'hffff_fff0);
    send_item(MODE_INSERT, 32'd10);
    write_capacity(5'd2);
    send_item(MODE_INSERT, 32'd99);
    send_item(MODE_REMOVE, 32'd0);
    send_item(MODE_REMOVE, 32'd0);
    send_item(MODE_INSERT, 32'd7);
    send_item(MODE_REMOVE, 32'd0);
    send_item(MODE_REMOVE, 32'd0);
    write_capacity(5'd0);
    send_item(MODE_INSERT, 32'd1);
    send_item(MODE_REMOVE, 32'd0);
    drain_results();
  endtask

  // bursts that mostly fill or mostly empty the queue
  task automatic test_random_traffic(input logic [CAP_W-1:0] cap, input int idle_pct,
                                     input int stall, input int n_items);
    int sent;
    int burst;
    int k;
    bit filling;
    write_capacity(cap);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    sent = 0;
    while (sent < n_items) begin
      burst   = $urandom_range(24, 1);
      filling = $urandom_range(1);
      for (k = 0; k < burst && sent < n_items; k++) begin
        if ($urandom_range(9) < (filling ? 8 : 2))
          send_item(MODE_INSERT, pick_value());
        else
          send_item(MODE_REMOVE, $urandom);
        sent++;
      end
      if ($urandom_range(7) == 0)
        drain_results();
    end
    drain_results();
  endtask

  // sequence of tests
  initial begin
    shadow_capacity = CAP_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_remove();
    test_extremes_and_ties();
    test_capacity_corners();

    test_random_traffic(5'd16, 0, 0, 120);
    test_random_traffic(5'd5, 55, 0, 90);
    test_random_traffic(5'd31, 0, 55, 120);
    test_random_traffic(5'd1, 29, 29, 60);
    test_random_traffic(5'd12, 29, 29, 60);

    // let any stray result show up
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (40) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

`default_nettype wire
